>>> src/afr_pkg.sv
`default_nettype none

package afr_pkg;

    // result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_LENERR = 2'd2;

    // configuration register map
    localparam int         CFG_ADDR_W       = 3;
    localparam logic       CFG_IDX_MAX_LEN  = 1'b0;
    localparam logic [15:0] MAX_LEN_RESET   = 16'd260;

    // one result item
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  class_byte;
        logic [7:0]  instr_byte;
        logic [15:0] data_length;
        logic [7:0]  data_value;
        logic [15:0] data_index;
        logic [15:0] expected_len;
    } afr_result_t;

    // parser to output stage
    typedef struct packed {
        logic        fire;
        logic        has_result;
        afr_result_t result;
    } afr_step_t;

endpackage

`default_nettype wire

>>> src/afr_if.sv
`default_nettype none

// received byte channel
interface afr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel
interface afr_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  class_byte;
    logic [7:0]  instr_byte;
    logic [15:0] data_length;
    logic [7:0]  data_value;
    logic [15:0] data_index;
    logic [15:0] expected_len;

    modport source (output valid, output result_kind, output class_byte,
                    output instr_byte, output data_length, output data_value,
                    output data_index, output expected_len, input ready);
    modport sink   (input valid, input result_kind, input class_byte,
                    input instr_byte, input data_length, input data_value,
                    input data_index, input expected_len, output ready);
endinterface

`default_nettype wire

>>> src/afr_cfg.sv
`default_nettype none

module afr_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [afr_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output logic [15:0]                        max_len
);
    import afr_pkg::*;

    logic        wr_en;
    logic        idx_hit;
    logic [15:0] max_len_reg;

    assign pready  = 1'b1;
    assign idx_hit = (paddr[CFG_ADDR_W-1] == CFG_IDX_MAX_LEN);
    assign wr_en   = psel && penable && pwrite && idx_hit;

    // max data length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (wr_en)
        begin
            max_len_reg <= pwdata[15:0];
        end
    end

    // read back
    always_comb
    begin
        prdata = 32'd0;
        if (idx_hit)
        begin
            prdata = {16'd0, max_len_reg};
        end
    end

    assign max_len = max_len_reg;

endmodule

`default_nettype wire

>>> src/afr_parser.sv
`default_nettype none

module afr_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [15:0]       max_len,
    output afr_pkg::afr_step_t     step
);
    import afr_pkg::*;

    // phase codes
    localparam logic [2:0] PH_CLASS  = 3'd0;
    localparam logic [2:0] PH_INSTR  = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_LEN_HI = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_EXP_LO = 3'd5;
    localparam logic [2:0] PH_EXP_HI = 3'd6;

    logic [2:0]  phase_reg,  phase_next;
    logic [7:0]  class_reg,  class_next;
    logic [7:0]  instr_reg,  instr_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] seen_reg,   seen_next;
    logic [7:0]  exp_lo_reg, exp_lo_next;
    logic        has_result;
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [15:0] index;
    logic [15:0] exp_len;

    // frame phase machine
    always_comb
    begin
        phase_next  = phase_reg;
        class_next  = class_reg;
        instr_next  = instr_reg;
        length_next = length_reg;
        seen_next   = seen_reg;
        exp_lo_next = exp_lo_reg;
        has_result  = 1'b0;
        kind        = KIND_DATA;
        value       = 8'd0;
        index       = 16'd0;
        exp_len     = 16'd0;
        unique case (phase_reg)
            PH_INSTR:
            begin
                instr_next = rx_byte;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                length_next = {8'd0, rx_byte};
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                length_next = {rx_byte, length_reg[7:0]};
                seen_next   = 16'd0;
                if (length_next > max_len)
                begin
                    // oversize frame
                    phase_next = PH_CLASS;
                    has_result = 1'b1;
                    kind       = KIND_LENERR;
                end
                else if (length_next == 16'd0)
                begin
                    phase_next = PH_EXP_LO;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                seen_next  = seen_reg + 16'd1;
                if (seen_next >= length_reg)
                begin
                    phase_next = PH_EXP_LO;
                end
                has_result = 1'b1;
                kind       = KIND_DATA;
                value      = rx_byte;
                index      = seen_reg;
            end
            PH_EXP_LO:
            begin
                exp_lo_next = rx_byte;
                phase_next  = PH_EXP_HI;
            end
            PH_EXP_HI:
            begin
                phase_next = PH_CLASS;
                has_result = 1'b1;
                kind       = KIND_DONE;
                exp_len    = {rx_byte, exp_lo_reg};
            end
            default:
            begin
                // class byte, also covers the unused code
                class_next = rx_byte;
                phase_next = PH_INSTR;
            end
        endcase
    end

    // state registers, updated per accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_CLASS;
            class_reg  <= 8'd0;
            instr_reg  <= 8'd0;
            length_reg <= 16'd0;
            seen_reg   <= 16'd0;
            exp_lo_reg <= 8'd0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            class_reg  <= class_next;
            instr_reg  <= instr_next;
            length_reg <= length_next;
            seen_reg   <= seen_next;
            exp_lo_reg <= exp_lo_next;
        end
    end

    // result for the output stage
    assign step.fire                = fire;
    assign step.has_result          = has_result;
    assign step.result.result_kind  = kind;
    assign step.result.class_byte   = class_next;
    assign step.result.instr_byte   = instr_next;
    assign step.result.data_length  = length_next;
    assign step.result.data_value   = value;
    assign step.result.data_index   = index;
    assign step.result.expected_len = exp_len;

endmodule

`default_nettype wire

>>> src/afr_out_stage.sv
`default_nettype none

module afr_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire afr_pkg::afr_step_t step,
    output logic                    take,
    afr_result_if.source            out_ch
);
    import afr_pkg::*;

    logic        valid_reg;
    afr_result_t data_reg;

    // register is free when empty or being drained this cycle
    assign take = !valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= step.fire && step.has_result;
        end
    end

    // payload holds while a transaction is stalled
    always_ff @(posedge clk)
    begin
        if (take && step.fire && step.has_result)
        begin
            data_reg <= step.result;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.result_kind  = data_reg.result_kind;
    assign out_ch.class_byte   = data_reg.class_byte;
    assign out_ch.instr_byte   = data_reg.instr_byte;
    assign out_ch.data_length  = data_reg.data_length;
    assign out_ch.data_value   = data_reg.data_value;
    assign out_ch.data_index   = data_reg.data_index;
    assign out_ch.expected_len = data_reg.expected_len;

endmodule

`default_nettype wire

>>> src/apdu_frame_receiver_unit.sv
`default_nettype none
// a result is registered and shown the cycle after the byte that causes it is accepted
// throughput: one byte per cycle unless the result receiver stalls; the phase machine updates on each accepted byte
// a byte is accepted while the output register is empty or being drained
// reset: asynchronous, active low; parser waits for a class byte, max length 260

module apdu_frame_receiver_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [afr_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    afr_byte_if.sink                            in_ch,
    afr_result_if.source                        out_ch
);
    import afr_pkg::*;

    logic       take;
    logic       fire;
    logic [15:0] max_len;
    afr_step_t  step;

    assign in_ch.ready = take;
    assign fire        = in_ch.valid && take;

    // configuration registers
    afr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_len (max_len)
    );

    // frame phase machine
    afr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (in_ch.rx_byte),
        .max_len (max_len),
        .step    (step)
    );

    // result register
    afr_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .take   (take),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

>>> test/apdu_frame_checker.sv
`default_nettype none

module apdu_frame_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [afr_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    input  wire logic                           pready,
    afr_byte_if                                 byte_ch,
    afr_result_if                               result_ch,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  data_count,
    output int                                  done_count,
    output int                                  lenerr_count,
    output logic                                at_frame_start
);
    timeunit 1ns;
    timeprecision 1ps;

    import afr_pkg::*;

    // where the deframer stands within a command frame
    typedef enum logic [2:0] {
        WAIT_CLASS,
        WAIT_INSTR,
        WAIT_LEN_LO,
        WAIT_LEN_HI,
        IN_DATA,
        WAIT_EXP_LO,
        WAIT_EXP_HI
    } parse_phase_t;

    parse_phase_t phase;
    logic [15:0]  max_len;
    logic [7:0]   cur_class;
    logic [7:0]   cur_instr;
    logic [15:0]  cur_len;
    logic [15:0]  data_seen;
    logic [7:0]   exp_low;

    afr_result_t  expected_results[$];

    // queue one predicted result built from the current header
    task automatic emit_result(input logic [1:0] kind, input logic [7:0] value,
                               input logic [15:0] index, input logic [15:0] exp_len);
        afr_result_t r;
        r.result_kind  = kind;
        r.class_byte   = cur_class;
        r.instr_byte   = cur_instr;
        r.data_length  = cur_len;
        r.data_value   = value;
        r.data_index   = index;
        r.expected_len = exp_len;
        expected_results.push_back(r);
    endtask

    // advance the frame parser by one received byte
    task automatic deframe_byte(input logic [7:0] b);
        case (phase)
            WAIT_INSTR:
            begin
                cur_instr = b;
                phase     = WAIT_LEN_LO;
            end
            WAIT_LEN_LO:
            begin
                cur_len = {8'h00, b};
                phase   = WAIT_LEN_HI;
            end
            WAIT_LEN_HI:
            begin
                cur_len   = {b, cur_len[7:0]};
                data_seen = 16'h0000;
                if (cur_len > max_len)
                begin
                    phase = WAIT_CLASS;
                    emit_result(KIND_LENERR, 8'h00, 16'h0000, 16'h0000);
                end
                else if (cur_len == 16'h0000)
                begin
                    phase = WAIT_EXP_LO;
                end
                else
                begin
                    phase = IN_DATA;
                end
            end
            IN_DATA:
            begin
                emit_result(KIND_DATA, b, data_seen, 16'h0000);
                data_seen = data_seen + 16'h0001;
                if (data_seen >= cur_len)
                    phase = WAIT_EXP_LO;
            end
            WAIT_EXP_LO:
            begin
                exp_low = b;
                phase   = WAIT_EXP_HI;
            end
            WAIT_EXP_HI:
            begin
                phase = WAIT_CLASS;
                emit_result(KIND_DONE, 8'h00, 16'h0000, {b, exp_low});
            end
            default:
            begin
                cur_class = b;
                phase     = WAIT_INSTR;
            end
        endcase
    endtask

    // compare one field of a result transaction
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // watch config writes, result and byte transactions
    always @(posedge clk or negedge rst_n)
    begin
        afr_result_t want;
        if (!rst_n)
        begin
            phase        = WAIT_CLASS;
            max_len      = MAX_LEN_RESET;
            cur_class    = 8'h00;
            cur_instr    = 8'h00;
            cur_len      = 16'h0000;
            data_seen    = 16'h0000;
            exp_low      = 8'h00;
            expected_results.delete();
            fail_count   = 0;
            pending      = 0;
            data_count   = 0;
            done_count   = 0;
            lenerr_count = 0;
            at_frame_start = 1'b1;
        end
        else
        begin
            if (psel && penable && pwrite && pready &&
                paddr[CFG_ADDR_W-1:2] == CFG_IDX_MAX_LEN)
                max_len = pwdata[15:0];

            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with nothing expected: kind %0d",
                           result_ch.result_kind);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("result_kind", 16'(want.result_kind),
                                16'(result_ch.result_kind));
                    check_field("class_byte", 16'(want.class_byte),
                                16'(result_ch.class_byte));
                    check_field("instr_byte", 16'(want.instr_byte),
                                16'(result_ch.instr_byte));
                    check_field("data_length", want.data_length, result_ch.data_length);
                    check_field("data_value", 16'(want.data_value),
                                16'(result_ch.data_value));
                    check_field("data_index", want.data_index, result_ch.data_index);
                    check_field("expected_len", want.expected_len, result_ch.expected_len);
                    case (want.result_kind)
                        KIND_DATA:   data_count++;
                        KIND_DONE:   done_count++;
                        default:     lenerr_count++;
                    endcase
                end
            end

            if (byte_ch.valid && byte_ch.ready)
                deframe_byte(byte_ch.rx_byte);

            pending        = expected_results.size();
            at_frame_start = (phase == WAIT_CLASS);
        end
    end

endmodule

`default_nettype wire

>>> test/tb_apdu_frame_receiver_unit.sv
`default_nettype none

module tb_apdu_frame_receiver_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import afr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_LEN  = {CFG_IDX_MAX_LEN, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = {1'b1, 2'b00};

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    afr_byte_if   byte_ch ();
    afr_result_if result_ch ();

    int   fail_count;
    int   pending;
    int   data_count;
    int   done_count;
    int   lenerr_count;
    logic at_frame_start;

    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    int          bytes_sent         = 0;
    int          quiet_cycles       = 0;
    int          settings_used      = 0;
    logic        byte_taken;
    logic [15:0] max_len_now        = MAX_LEN_RESET;

    apdu_frame_receiver_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (byte_ch),
        .out_ch  (result_ch)
    );

    apdu_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .byte_ch        (byte_ch),
        .result_ch      (result_ch),
        .fail_count     (fail_count),
        .pending        (pending),
        .data_count     (data_count),
        .done_count     (done_count),
        .lenerr_count   (lenerr_count),
        .at_frame_start (at_frame_start)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result receiver with random stalls
    always @(negedge clk)
        result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);

    // byte transaction seen at the last rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_taken <= 1'b0;
        else
            byte_taken <= byte_ch.valid && byte_ch.ready;
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // present one byte, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        @(negedge clk);
        while (!byte_taken)
            @(negedge clk);
        bytes_sent++;
    endtask

    // drop valid and wait until every expected result is out
    task automatic drain_results();
        byte_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // register write once the block is idle
    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
        drain_results();
        repeat (4) @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MAX_LEN)
        begin
            max_len_now = value[15:0];
            settings_used++;
        end
    endtask

    // one command frame; stops after the header on a length error
    task automatic send_frame(input logic [7:0] cls, input logic [7:0] ins,
                              input logic [15:0] len, input logic [15:0] exp_len);
        send_byte(cls);
        send_byte(ins);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        if (len <= max_len_now)
        begin
            for (int i = 0; i < len; i++)
                send_byte(8'($urandom_range(255)));
            send_byte(exp_len[7:0]);
            send_byte(exp_len[15:8]);
        end
    endtask

    // data length for a random frame, mostly short
    function automatic logic [15:0] pick_length();
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 12)
            return 16'h0000;
        else if (r < 64)
            return 16'($urandom_range(8, 1));
        else if (r < 70 && max_len_now <= 300)
        begin
            v = int'(max_len_now) + int'($urandom_range(2)) - 1;
            return (v < 0) ? 16'h0000 : v[15:0];
        end
        else if (max_len_now < 16'hFFFF)
            return 16'($urandom_range(65535, int'(max_len_now) + 1));
        else
            return 16'($urandom_range(24, 1));
    endfunction

    // random frames with some stray bytes that break the framing
    task automatic random_traffic(input int n_items);
        int target;
        target = bytes_sent + n_items;
        while (bytes_sent < target)
        begin
            if ($urandom_range(99) < 85 || max_len_now > 300)
                send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), pick_length(),
                           16'($urandom_range(65535)));
            else
            begin
                repeat ($urandom_range(6, 1))
                    send_byte(8'($urandom_range(255)));
                // random filler until the parser is back at a class byte
                while (!at_frame_start)
                    send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    // stimulus
    initial
    begin
        logic [7:0] directed_bytes[25];
        directed_bytes = '{
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,          // all-zero frame, no data
            8'hFF, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'hFF,   // all-ones frame, one byte
            8'h5A, 8'hA5, 8'h05, 8'h01,                        // length one above reset max
            8'hC3, 8'h3C, 8'h02, 8'h00, 8'h00, 8'hAA, 8'h34, 8'h12
        };

        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = 8'h00;
        result_ch.ready = 1'b0;
        rst_n           = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed frames at reset settings
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        // zero max length: every nonzero length is refused
        write_register(ADDR_MAX_LEN, 32'h0000_0000);
        write_register(ADDR_UNMAPPED, $urandom);
        random_traffic(150);

        // full max length: a frame above the reset limit is taken; at FFFE a length of FFFF is refused
        write_register(ADDR_MAX_LEN, 32'h0000_FFFF);
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 16'd261,
                   16'($urandom_range(65535)));
        random_traffic(100);
        write_register(ADDR_MAX_LEN, 32'hFFFF_FFFE);
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 16'hFFFF,
                   16'($urandom_range(65535)));

        // sender idles often
        write_register(ADDR_MAX_LEN, {16'h0000, MAX_LEN_RESET});
        sender_idle_pct = 74;
        random_traffic(450);

        // receiver stalls often
        sender_idle_pct = 0;
        write_register(ADDR_MAX_LEN, $urandom_range(64, 1));
        receiver_stall_pct = 74;
        random_traffic(450);

        // both sides idle now and then, with a full pause in the middle
        write_register(ADDR_MAX_LEN, 32'd300);
        sender_idle_pct    = 11;
        receiver_stall_pct = 11;
        random_traffic(225);
        drain_results();
        random_traffic(225);

        drain_results();
        repeat (10) @(negedge clk);

        $display("covered %0d bytes under %0d max-length settings and four idle patterns",
                 bytes_sent, settings_used);
        $display("results: %0d data bytes, %0d complete frames, %0d length errors",
                 data_count, done_count, lenerr_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
